@@ rtl/two_level_tlb_lookup_unit_defines.svh @@
// Assertion macros shared by the two-level TLB lookup RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TWO_LEVEL_TLB_LOOKUP_UNIT_DEFINES_SVH
`define TWO_LEVEL_TLB_LOOKUP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Concurrent check, switched off while reset is asserted.
`define TLB2_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Concurrent check that also holds during reset.
`define TLB2_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLB2_ASSERT(lbl, clk, rstn, prop, msg)
`define TLB2_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/tlb2_pkg.sv @@
// Package for the two-level TLB lookup unit: codes, field widths, defaults.
// No dependencies; used by tlb2_l1 and the top level of the block.
`default_nettype none

package tlb2_pkg;

  // Default sizes of the block
  localparam int unsigned L1_INDEX_BITS_DEF = 4;
  localparam int unsigned L2_INDEX_BITS_DEF = 6;
  localparam int unsigned VPN_BITS_DEF      = 36;
  localparam int unsigned PPN_BITS_DEF      = 20;

  // Fixed field widths
  localparam int unsigned OFFSET_BITS = 12;
  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned CMD_BITS    = 2;
  localparam int unsigned TARGET_BITS = 2;
  localparam int unsigned IN_USER_W   = CMD_BITS + 1 + TARGET_BITS;

  // Command carried with each input word
  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  // Which TLB a flush clears
  typedef enum logic [TARGET_BITS-1:0] {
    TGT_L1I = 2'd0,
    TGT_L1D = 2'd1,
    TGT_L2  = 2'd2
  } target_e;

  // Result status
  typedef enum logic [STATUS_BITS-1:0] {
    ST_L1_HIT  = 3'd0,
    ST_L2_HIT  = 3'd1,
    ST_WALK    = 3'd2,
    ST_FILLED  = 3'd3,
    ST_FAULT   = 3'd4,
    ST_FLUSHED = 3'd5
  } status_e;

  // Access kind
  localparam logic KIND_INSTR = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Update controls for one first-level TLB
  typedef struct packed {
    logic write;
    logic inval;
    logic flush;
  } l1_ctl_t;

endpackage

`default_nettype wire

@@ rtl/tlb2_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the tag and page of the second-level TLB.
`default_nettype none

module tlb2_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; a read of the address written in the same cycle
  // returns the old contents.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/tlb2_l1.sv @@
// One direct-mapped first-level TLB: valid bits, tags and pages in flops.
// Depends on tlb2_pkg for the update control struct.
`default_nettype none

module tlb2_l1 #(
  parameter int unsigned IDX_BITS  = 4,
  parameter int unsigned TAG_BITS  = 32,
  parameter int unsigned PAGE_BITS = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tlb2_pkg::l1_ctl_t     ctl_i,
  input  wire logic [IDX_BITS-1:0]   idx_i,
  input  wire logic [TAG_BITS-1:0]   wtag_i,
  input  wire logic [PAGE_BITS-1:0]  wpage_i,
  output logic                       valid_o,
  output logic      [TAG_BITS-1:0]   tag_o,
  output logic      [PAGE_BITS-1:0]  page_o
);

  localparam int unsigned LINES = 1 << IDX_BITS;

  logic [LINES-1:0]     valid_q;
  logic [LINES-1:0]     valid_d;
  logic [TAG_BITS-1:0]  tag_q  [LINES];
  logic [PAGE_BITS-1:0] page_q [LINES];

  // Line read at the index of the current word
  assign valid_o = valid_q[idx_i];
  assign tag_o   = tag_q[idx_i];
  assign page_o  = page_q[idx_i];

  // Valid bits: flush clears all lines, a write sets one, an invalidate clears one.
  // An invalid line is never looked at, so flush leaves tag and page alone.
  always_comb begin
    valid_d = valid_q;
    priority if (ctl_i.flush) begin
      valid_d = '0;
    end else if (ctl_i.write) begin
      valid_d[idx_i] = 1'b1;
    end else if (ctl_i.inval) begin
      valid_d[idx_i] = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Line contents
  always_ff @(posedge clk_i) begin
    if (ctl_i.write && !ctl_i.flush) begin
      tag_q[idx_i]  <= wtag_i;
      page_q[idx_i] <= wpage_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/two_level_tlb_lookup_unit.sv @@
// Top level of the two-level TLB lookup unit.
// Depends on tlb2_pkg, tlb2_l1, tlb2_ram and two_level_tlb_lookup_unit_defines.svh.
//
// Usage:
//   Command words enter on the s_axis channel: tuser carries the command, the
//   access kind and the flush target, tdata the virtual page, page offset,
//   walked page and walk fault. Each lookup, fill or flush returns one result
//   word on the m_axis channel with the status in tuser and the physical page
//   and offset in tdata. An unused command code is consumed with no result.
//   A word passes through the input register and then the output register.
//   One word per cycle is sustained while the receiver takes results; the pace
//   is set by the second-level TLB RAM, read as the word is accepted, and by the
//   first-level flops, read and written while the word is in the input register.
//   A RAM write that meets a read of the same line in the same cycle is forwarded.
//   Reset clears every valid bit, so all three TLBs come up empty, and both
//   channels come up empty. When the receiver stalls, the result holds in the
//   output register and one further word is taken into the input register;
//   after that s_axis_tready_o falls until the result is taken.
`default_nettype none
`include "two_level_tlb_lookup_unit_defines.svh"

module two_level_tlb_lookup_unit #(
  parameter int unsigned L1_INDEX_BITS = tlb2_pkg::L1_INDEX_BITS_DEF,
  parameter int unsigned L2_INDEX_BITS = tlb2_pkg::L2_INDEX_BITS_DEF,
  parameter int unsigned VPN_BITS      = tlb2_pkg::VPN_BITS_DEF,
  parameter int unsigned PPN_BITS      = tlb2_pkg::PPN_BITS_DEF,
  localparam int unsigned IN_BITS      = VPN_BITS + tlb2_pkg::OFFSET_BITS + PPN_BITS + 1,
  localparam int unsigned IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS     = PPN_BITS + tlb2_pkg::OFFSET_BITS,
  localparam int unsigned OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Command words
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata, from bit 0: virtual_page, in_offset, walked_page, walk_fault, zero pad
  input  wire logic [IN_TDATA_W-1:0]            s_axis_tdata_i,
  // tuser, from bit 0: command, access_kind, flush_target
  input  wire logic [tlb2_pkg::IN_USER_W-1:0]   s_axis_tuser_i,
  // Result words
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // tdata, from bit 0: physical_page, out_offset, zero pad
  output logic      [OUT_TDATA_W-1:0]           m_axis_tdata_o,
  // tuser, from bit 0: status
  output logic      [tlb2_pkg::STATUS_BITS-1:0] m_axis_tuser_o
);

  localparam int unsigned OFF_BITS  = tlb2_pkg::OFFSET_BITS;
  localparam int unsigned L1_TAG_W  = VPN_BITS - L1_INDEX_BITS;
  localparam int unsigned L2_TAG_W  = VPN_BITS - L2_INDEX_BITS;
  localparam int unsigned L2_LINES  = 1 << L2_INDEX_BITS;
  localparam int unsigned L2_WORD_W = L2_TAG_W + PPN_BITS;

  // Input unpacking
  logic                      s_accept;
  logic [VPN_BITS-1:0]       in_vpn;
  logic [L2_INDEX_BITS-1:0]  in_i2;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign in_vpn   = s_axis_tdata_i[VPN_BITS-1:0];
  assign in_i2    = in_vpn[L2_INDEX_BITS-1:0];

  // Input register
  logic                      s1_valid_q;
  tlb2_pkg::cmd_e            s1_cmd_q;
  logic                      s1_kind_q;
  tlb2_pkg::target_e         s1_target_q;
  logic [VPN_BITS-1:0]       s1_vpn_q;
  logic [OFF_BITS-1:0]       s1_off_q;
  logic [PPN_BITS-1:0]       s1_walked_q;
  logic                      s1_fault_q;
  logic                      s1_fwd_q;
  logic [L2_WORD_W-1:0]      s1_fwd_data_q;
  logic                      s1_fire;

  // Output register
  logic                      out_valid_q;
  tlb2_pkg::status_e         out_status_q;
  logic [PPN_BITS-1:0]       out_page_q;
  logic [OFF_BITS-1:0]       out_off_q;

  // Second-level TLB
  logic [L2_LINES-1:0]       l2_valid_q;
  logic [L2_LINES-1:0]       l2_valid_d;
  logic                      l2_we;
  logic                      l2_flush;
  logic [L2_WORD_W-1:0]      l2_wdata;
  logic [L2_WORD_W-1:0]      l2_rdata_ram;
  logic [L2_WORD_W-1:0]      l2_rdata;
  logic [L2_TAG_W-1:0]       l2_tag_rd;
  logic [PPN_BITS-1:0]       l2_page_rd;

  // First-level TLBs
  tlb2_pkg::l1_ctl_t         l1i_ctl;
  tlb2_pkg::l1_ctl_t         l1d_ctl;
  logic                      l1i_valid;
  logic                      l1d_valid;
  logic [L1_TAG_W-1:0]       l1i_tag;
  logic [L1_TAG_W-1:0]       l1d_tag;
  logic [PPN_BITS-1:0]       l1i_page;
  logic [PPN_BITS-1:0]       l1d_page;
  logic [PPN_BITS-1:0]       l1_wpage;

  // Fields of the word in the input register
  logic [L1_INDEX_BITS-1:0]  i1;
  logic [L1_TAG_W-1:0]       t1;
  logic [L2_INDEX_BITS-1:0]  i2;
  logic [L2_TAG_W-1:0]       t2;

  assign i1 = s1_vpn_q[L1_INDEX_BITS-1:0];
  assign t1 = s1_vpn_q[VPN_BITS-1:L1_INDEX_BITS];
  assign i2 = s1_vpn_q[L2_INDEX_BITS-1:0];
  assign t2 = s1_vpn_q[VPN_BITS-1:L2_INDEX_BITS];

  // Handshake: the input register moves on whenever the output register is free
  assign s1_fire         = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_fire;

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else begin
      if (s_accept) begin
        s1_valid_q <= 1'b1;
        s1_fwd_q   <= l2_we && (in_i2 == i2);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_cmd_q      <= tlb2_pkg::cmd_e'(s_axis_tuser_i[tlb2_pkg::CMD_BITS-1:0]);
      s1_kind_q     <= s_axis_tuser_i[tlb2_pkg::CMD_BITS];
      s1_target_q   <= tlb2_pkg::target_e'(
                         s_axis_tuser_i[tlb2_pkg::CMD_BITS+1 +: tlb2_pkg::TARGET_BITS]);
      s1_vpn_q      <= in_vpn;
      s1_off_q      <= s_axis_tdata_i[VPN_BITS +: OFF_BITS];
      s1_walked_q   <= s_axis_tdata_i[VPN_BITS+OFF_BITS +: PPN_BITS];
      s1_fault_q    <= s_axis_tdata_i[VPN_BITS+OFF_BITS+PPN_BITS];
      s1_fwd_data_q <= l2_wdata;
    end
  end

  // Second-level tag and page store, read as the word is accepted
  tlb2_ram #(
    .WIDTH (L2_WORD_W),
    .DEPTH (L2_LINES)
  ) u_l2_ram (
    .clk_i   (clk_i),
    .we_i    (l2_we),
    .waddr_i (i2),
    .wdata_i (l2_wdata),
    .re_i    (s_accept),
    .raddr_i (in_i2),
    .rdata_o (l2_rdata_ram)
  );

  // A fill that wrote the line in the cycle of the read is forwarded
  assign l2_rdata   = s1_fwd_q ? s1_fwd_data_q : l2_rdata_ram;
  assign l2_tag_rd  = l2_rdata[L2_WORD_W-1:PPN_BITS];
  assign l2_page_rd = l2_rdata[PPN_BITS-1:0];
  assign l2_wdata   = {t2, s1_walked_q};

  // First-level TLBs
  tlb2_l1 #(
    .IDX_BITS  (L1_INDEX_BITS),
    .TAG_BITS  (L1_TAG_W),
    .PAGE_BITS (PPN_BITS)
  ) u_l1i (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (l1i_ctl),
    .idx_i   (i1),
    .wtag_i  (t1),
    .wpage_i (l1_wpage),
    .valid_o (l1i_valid),
    .tag_o   (l1i_tag),
    .page_o  (l1i_page)
  );

  tlb2_l1 #(
    .IDX_BITS  (L1_INDEX_BITS),
    .TAG_BITS  (L1_TAG_W),
    .PAGE_BITS (PPN_BITS)
  ) u_l1d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (l1d_ctl),
    .idx_i   (i1),
    .wtag_i  (t1),
    .wpage_i (l1_wpage),
    .valid_o (l1d_valid),
    .tag_o   (l1d_tag),
    .page_o  (l1d_page)
  );

  // Lookup, fill and flush decision for the word in the input register
  logic                  own_valid;
  logic [L1_TAG_W-1:0]   own_tag;
  logic [PPN_BITS-1:0]   own_page;
  logic                  oth_valid;
  logic [L1_TAG_W-1:0]   oth_tag;
  logic                  l1_hit;
  logic                  l2_line_valid;
  logic                  l2_hit;
  logic                  evict_match;
  logic                  own_write;
  logic                  oth_inval;
  logic                  res_valid;
  tlb2_pkg::status_e     res_status;
  logic [PPN_BITS-1:0]   res_page;
  logic [OFF_BITS-1:0]   res_off;

  assign own_valid     = (s1_kind_q == tlb2_pkg::KIND_DATA) ? l1d_valid : l1i_valid;
  assign own_tag       = (s1_kind_q == tlb2_pkg::KIND_DATA) ? l1d_tag   : l1i_tag;
  assign own_page      = (s1_kind_q == tlb2_pkg::KIND_DATA) ? l1d_page  : l1i_page;
  assign oth_valid     = (s1_kind_q == tlb2_pkg::KIND_DATA) ? l1i_valid : l1d_valid;
  assign oth_tag       = (s1_kind_q == tlb2_pkg::KIND_DATA) ? l1i_tag   : l1d_tag;
  assign l1_hit        = own_valid && (own_tag == t1);
  assign l2_line_valid = l2_valid_q[i2];
  assign l2_hit        = l2_line_valid && (l2_tag_rd == t2);
  // The other first-level line holds the very page the fill evicts
  assign evict_match   = l2_line_valid && oth_valid && ({oth_tag, i1} == {l2_tag_rd, i2});

  always_comb begin
    res_valid  = 1'b0;
    res_status = tlb2_pkg::ST_WALK;
    res_page   = '0;
    res_off    = '0;
    own_write  = 1'b0;
    oth_inval  = 1'b0;
    l2_we      = 1'b0;
    l2_flush   = 1'b0;
    l1_wpage   = s1_walked_q;
    l1i_ctl    = '0;
    l1d_ctl    = '0;
    if (s1_fire) begin
      unique case (s1_cmd_q)
        tlb2_pkg::CMD_LOOKUP: begin
          res_valid = 1'b1;
          if (l1_hit) begin
            res_status = tlb2_pkg::ST_L1_HIT;
            res_page   = own_page;
            res_off    = s1_off_q;
          end else if (l2_hit) begin
            res_status = tlb2_pkg::ST_L2_HIT;
            res_page   = l2_page_rd;
            res_off    = s1_off_q;
            own_write  = 1'b1;
            l1_wpage   = l2_page_rd;
          end
        end
        tlb2_pkg::CMD_FILL: begin
          res_valid = 1'b1;
          if (s1_fault_q) begin
            res_status = tlb2_pkg::ST_FAULT;
          end else begin
            res_status = tlb2_pkg::ST_FILLED;
            res_page   = s1_walked_q;
            res_off    = s1_off_q;
            own_write  = 1'b1;
            oth_inval  = evict_match;
            l2_we      = 1'b1;
          end
        end
        tlb2_pkg::CMD_FLUSH: begin
          res_valid  = 1'b1;
          res_status = tlb2_pkg::ST_FLUSHED;
          unique case (s1_target_q)
            tlb2_pkg::TGT_L1I: l1i_ctl.flush = 1'b1;
            tlb2_pkg::TGT_L1D: l1d_ctl.flush = 1'b1;
            tlb2_pkg::TGT_L2:  l2_flush      = 1'b1;
            default: ;
          endcase
        end
        default: ;
      endcase
      if (s1_kind_q == tlb2_pkg::KIND_DATA) begin
        l1d_ctl.write = own_write;
        l1i_ctl.inval = oth_inval;
      end else begin
        l1i_ctl.write = own_write;
        l1d_ctl.inval = oth_inval;
      end
    end
  end

  // Second-level valid bits
  always_comb begin
    l2_valid_d = l2_valid_q;
    priority if (l2_flush) begin
      l2_valid_d = '0;
    end else if (l2_we) begin
      l2_valid_d[i2] = 1'b1;
    end else begin
      l2_valid_d = l2_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l2_valid_q <= '0;
    end else begin
      l2_valid_q <= l2_valid_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && res_valid) begin
      out_status_q <= res_status;
      out_page_q   <= res_page;
      out_off_q    <= res_off;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_off_q, out_page_q});

  // Checks
  `TLB2_ASSERT(a_ready_only_blocked_by_word, clk_i, rst_ni, !s_axis_tready_o |-> s1_valid_q, "input stalled with an empty input register")
  `TLB2_ASSERT(a_no_translation_zero, clk_i, rst_ni, out_valid_q && (out_status_q == tlb2_pkg::ST_WALK || out_status_q == tlb2_pkg::ST_FAULT || out_status_q == tlb2_pkg::ST_FLUSHED) |-> out_page_q == '0 && out_off_q == '0, "result without translation carries a page or offset")
  `TLB2_ASSERT(a_result_from_word, clk_i, rst_ni, $rose(out_valid_q) |-> $past(s1_valid_q), "result appeared without a word in the input register")
  `TLB2_ASSERT(a_fill_sets_l2_valid, clk_i, rst_ni, l2_we |=> l2_valid_q[$past(i2)], "second-level line not valid after a fill")
  `TLB2_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_q && !s1_valid_q, "pipeline not empty during reset")

endmodule

`default_nettype wire

@@ sim/tb_two_level_tlb_lookup_unit.sv @@
// Self-checking testbench for the two-level TLB lookup unit: it drives command words with
// random gaps, mirrors the L1/L2 TLB contents and checks every result word in order.
// Depends on tlb2_pkg and two_level_tlb_lookup_unit.
`timescale 1ns / 100ps

import tlb2_pkg::*;

localparam int unsigned L1_IDX   = L1_INDEX_BITS_DEF;
localparam int unsigned L2_IDX   = L2_INDEX_BITS_DEF;
localparam int unsigned VPN_W    = VPN_BITS_DEF;
localparam int unsigned PPN_W    = PPN_BITS_DEF;
localparam int unsigned L1_LINES = 1 << L1_IDX;
localparam int unsigned L2_LINES = 1 << L2_IDX;

// Codes outside the defined sets, still legal on the wires.
localparam logic [CMD_BITS-1:0]    CMD_UNUSED = 2'd3;
localparam logic [TARGET_BITS-1:0] TGT_NONE   = 2'd3;

// One expected result word.
typedef struct packed {
  status_e                  status;
  logic [PPN_W-1:0]         ppn;
  logic [OFFSET_BITS-1:0]   offset;
} xlat_result_t;

// Mirror of the three TLBs plus the queue of translations still to come out.
class tlb_translation_tracker;
  bit                      l1i_ok  [L1_LINES];
  bit [VPN_W-L1_IDX-1:0]   l1i_tag [L1_LINES];
  bit [PPN_W-1:0]          l1i_ppn [L1_LINES];
  bit                      l1d_ok  [L1_LINES];
  bit [VPN_W-L1_IDX-1:0]   l1d_tag [L1_LINES];
  bit [PPN_W-1:0]          l1d_ppn [L1_LINES];
  bit                      l2_ok   [L2_LINES];
  bit [VPN_W-L2_IDX-1:0]   l2_tag  [L2_LINES];
  bit [PPN_W-1:0]          l2_ppn  [L2_LINES];
  xlat_result_t            translations_due[$];
  int                      errors;

  function int pending();
    return translations_due.size();
  endfunction

  function void fill_first_level(logic kind, logic [VPN_W-1:0] vpn, logic [PPN_W-1:0] ppn);
    logic [L1_IDX-1:0] idx;
    idx = vpn[L1_IDX-1:0];
    if (kind == KIND_DATA) begin
      l1d_ok[idx] = 1'b1; l1d_tag[idx] = vpn[VPN_W-1:L1_IDX]; l1d_ppn[idx] = ppn;
    end else begin
      l1i_ok[idx] = 1'b1; l1i_tag[idx] = vpn[VPN_W-1:L1_IDX]; l1i_ppn[idx] = ppn;
    end
  endfunction

  // Work out the result of an accepted command word and update the mirror.
  function void record_request(logic [CMD_BITS-1:0] cmd, logic kind, logic [VPN_W-1:0] vpn,
                               logic [OFFSET_BITS-1:0] offset, logic [PPN_W-1:0] walked,
                               logic fault, logic [TARGET_BITS-1:0] target);
    logic [L1_IDX-1:0]       i1;
    logic [VPN_W-L1_IDX-1:0] t1;
    logic [L2_IDX-1:0]       i2;
    logic [VPN_W-L2_IDX-1:0] t2;
    logic [VPN_W-1:0]        old_vpn;
    logic                    l1_hit;
    xlat_result_t            res;
    i1 = vpn[L1_IDX-1:0];
    t1 = vpn[VPN_W-1:L1_IDX];
    i2 = vpn[L2_IDX-1:0];
    t2 = vpn[VPN_W-1:L2_IDX];
    if (cmd == CMD_LOOKUP) begin
      l1_hit = (kind == KIND_DATA) ? (l1d_ok[i1] && l1d_tag[i1] == t1)
                                   : (l1i_ok[i1] && l1i_tag[i1] == t1);
      if (l1_hit) begin
        res = '{ST_L1_HIT, (kind == KIND_DATA) ? l1d_ppn[i1] : l1i_ppn[i1], offset};
      end else if (l2_ok[i2] && l2_tag[i2] == t2) begin
        fill_first_level(kind, vpn, l2_ppn[i2]);
        res = '{ST_L2_HIT, l2_ppn[i2], offset};
      end else begin
        res = '{ST_WALK, {PPN_W{1'b0}}, {OFFSET_BITS{1'b0}}};
      end
      translations_due.push_back(res);
    end else if (cmd == CMD_FILL) begin
      if (fault) begin
        res = '{ST_FAULT, {PPN_W{1'b0}}, {OFFSET_BITS{1'b0}}};
      end else begin
        // The other L1 loses its line if it maps the L2 entry being evicted.
        if (l2_ok[i2]) begin
          old_vpn = {l2_tag[i2], i2};
          if (kind == KIND_DATA) begin
            if (l1i_ok[i1] && {l1i_tag[i1], i1} == old_vpn) l1i_ok[i1] = 1'b0;
          end else begin
            if (l1d_ok[i1] && {l1d_tag[i1], i1} == old_vpn) l1d_ok[i1] = 1'b0;
          end
        end
        l2_ok[i2]  = 1'b1;
        l2_tag[i2] = t2;
        l2_ppn[i2] = walked;
        fill_first_level(kind, vpn, walked);
        res = '{ST_FILLED, walked, offset};
      end
      translations_due.push_back(res);
    end else if (cmd == CMD_FLUSH) begin
      case (target)
        TGT_L1I: foreach (l1i_ok[i]) begin
          l1i_ok[i] = 1'b0; l1i_tag[i] = '0; l1i_ppn[i] = '0;
        end
        TGT_L1D: foreach (l1d_ok[i]) begin
          l1d_ok[i] = 1'b0; l1d_tag[i] = '0; l1d_ppn[i] = '0;
        end
        TGT_L2: foreach (l2_ok[i]) begin
          l2_ok[i] = 1'b0; l2_tag[i] = '0; l2_ppn[i] = '0;
        end
        default: ;
      endcase
      res = '{ST_FLUSHED, {PPN_W{1'b0}}, {OFFSET_BITS{1'b0}}};
      translations_due.push_back(res);
    end
  endfunction

  // Compare a result word with the oldest outstanding translation.
  function void check_translation(logic [STATUS_BITS-1:0] status, logic [PPN_W-1:0] ppn,
                                  logic [OFFSET_BITS-1:0] offset);
    xlat_result_t exp;
    if (translations_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result word with nothing outstanding: status %0d page %h offset %h",
                 $time, status, ppn, offset);
      return;
    end
    exp = translations_due.pop_front();
    if (status !== exp.status || ppn !== exp.ppn || offset !== exp.offset) begin
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch: status exp %0d got %0d, page exp %h got %h, offset exp %h got %h",
                 $time, exp.status, status, exp.ppn, ppn, exp.offset, offset);
    end
  endfunction
endclass

module tb_two_level_tlb_lookup_unit;

  localparam int unsigned RANDOM_ITEMS = 730;
  localparam int unsigned CHUNK_ITEMS  = 40;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned POOL_SIZE    = 24;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready_o;
  logic [71:0]                s_axis_tdata;
  logic [IN_USER_W-1:0]       s_axis_tuser;
  logic                       m_axis_tvalid_o;
  logic                       m_axis_tready;
  logic [31:0]                m_axis_tdata_o;
  logic [STATUS_BITS-1:0]     m_axis_tuser_o;

  tlb_translation_tracker     translations;
  int                         tx_max_gap = 18;
  int                         rx_max_gap = 18;
  bit                         hold_results = 1'b0;

  two_level_tlb_lookup_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // 100 MHz clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Present one command word after a random gap and wait until it is taken.
  task automatic send_request(input logic [CMD_BITS-1:0] cmd, input logic kind,
                              input logic [VPN_W-1:0] vpn, input logic [OFFSET_BITS-1:0] offset,
                              input logic [PPN_W-1:0] walked, input logic fault,
                              input logic [TARGET_BITS-1:0] target);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, fault, walked, offset, vpn};
    s_axis_tuser  <= {target, kind, cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Stop sending and wait until every outstanding translation has come out.
  task automatic wait_translations_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (translations.pending() != 0) @(posedge clk_i);
  endtask

  // Accepted words on both channels feed the tracker.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready)
        translations.check_translation(m_axis_tuser_o, m_axis_tdata_o[PPN_W-1:0],
                                       m_axis_tdata_o[PPN_W+OFFSET_BITS-1:PPN_W]);
      if (s_axis_tvalid && s_axis_tready_o)
        translations.record_request(s_axis_tuser[1:0], s_axis_tuser[2], s_axis_tdata[35:0],
                                    s_axis_tdata[47:36], s_axis_tdata[67:48], s_axis_tdata[68],
                                    s_axis_tuser[4:3]);
    end
  end

  // Result receiver: a random stall before each word, or one long hold on request.
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_results) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_results = 1'b0;
      end else begin
        stall = $urandom_range(0, rx_max_gap);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Guard against a hung block.
  initial begin
    #5_000_000;
    $display("two_level_tlb_lookup_unit verification failed");
    $finish;
  end

  // Stimulus.
  initial begin
    logic [VPN_W-1:0]       page_pool [POOL_SIZE];
    logic [VPN_W-1:0]       vpn;
    logic [VPN_W-1:0]       last_vpn;
    logic [CMD_BITS-1:0]    cmd;
    logic                   kind;
    logic                   last_kind;
    logic                   last_was_lookup;
    logic                   fault;
    int                     issued;
    int                     chunk;
    int                     r;

    translations  = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty TLBs, fault, both hit paths, eviction, every flush target.
    send_request(CMD_LOOKUP, KIND_INSTR, 36'h0, 12'h000, 20'h00000, 1'b0, TGT_L1I);
    send_request(CMD_FILL, KIND_INSTR, 36'h0, 12'hFFF, 20'hFFFFF, 1'b1, TGT_L2);
    send_request(CMD_LOOKUP, KIND_INSTR, 36'h0, 12'hABC, 20'h00000, 1'b0, TGT_L1I);
    send_request(CMD_FILL, KIND_INSTR, 36'hF_FFFF_FFFF, 12'hFFF, 20'hFFFFF, 1'b0, TGT_NONE);
    send_request(CMD_LOOKUP, KIND_INSTR, 36'hF_FFFF_FFFF, 12'h000, 20'h00000, 1'b0, TGT_L1I);
    send_request(CMD_LOOKUP, KIND_DATA, 36'hF_FFFF_FFFF, 12'h555, 20'hFFFFF, 1'b1, TGT_L1D);
    send_request(CMD_LOOKUP, KIND_DATA, 36'hF_FFFF_FFFF, 12'hAAA, 20'h00000, 1'b0, TGT_L1D);
    // Same L2 line, other tag: the data L1 copy of the old page must go.
    send_request(CMD_FILL, KIND_INSTR, 36'h7_FFFF_FFFF, 12'h123, 20'h12345, 1'b0, TGT_L1I);
    send_request(CMD_LOOKUP, KIND_DATA, 36'hF_FFFF_FFFF, 12'h001, 20'h00000, 1'b0, TGT_L1I);
    send_request(CMD_LOOKUP, KIND_INSTR, 36'hF_FFFF_FFFF, 12'h002, 20'h00000, 1'b0, TGT_L1I);
    send_request(CMD_LOOKUP, KIND_INSTR, 36'h7_FFFF_FFFF, 12'h800, 20'h00000, 1'b0, TGT_L1I);
    send_request(CMD_FILL, KIND_DATA, 36'h0, 12'h000, 20'h00000, 1'b0, TGT_L1I);
    send_request(CMD_LOOKUP, KIND_DATA, 36'h0, 12'h7FF, 20'h00000, 1'b0, TGT_L1I);
    send_request(CMD_FLUSH, KIND_DATA, 36'h0, 12'h000, 20'h00000, 1'b0, TGT_L1D);
    send_request(CMD_LOOKUP, KIND_DATA, 36'h0, 12'h3C3, 20'h00000, 1'b0, TGT_L1I);
    send_request(CMD_FLUSH, KIND_INSTR, 36'hF_FFFF_FFFF, 12'hFFF, 20'hFFFFF, 1'b1, TGT_L1I);
    send_request(CMD_FLUSH, KIND_DATA, 36'h0, 12'h000, 20'h00000, 1'b0, TGT_L2);
    send_request(CMD_FLUSH, KIND_DATA, 36'h0, 12'h000, 20'h00000, 1'b0, TGT_NONE);
    send_request(CMD_LOOKUP, KIND_INSTR, 36'h7_FFFF_FFFF, 12'h010, 20'h00000, 1'b0, TGT_L1I);
    send_request(CMD_LOOKUP, KIND_DATA, 36'h0, 12'h020, 20'h00000, 1'b0, TGT_L1I);
    send_request(CMD_UNUSED, KIND_DATA, 36'hF_FFFF_FFFF, 12'hFFF, 20'hFFFFF, 1'b1, TGT_NONE);
    send_request(CMD_LOOKUP, KIND_DATA, 36'h0, 12'h040, 20'h00000, 1'b0, TGT_L1I);

    // Random part: a small page pool with crowded indices so lines hit, conflict and evict.
    issued          = 0;
    chunk           = 0;
    last_was_lookup = 1'b0;
    last_vpn        = '0;
    last_kind       = KIND_INSTR;
    foreach (page_pool[k]) begin
      page_pool[k]         = VPN_W'({$urandom, $urandom});
      page_pool[k][5:0]    = 6'($urandom_range(0, 11));
    end
    while (issued < RANDOM_ITEMS) begin
      r = $urandom_range(0, 2);
      tx_max_gap = (r == 0) ? 0 : (r == 1) ? 4 : 18;
      r = $urandom_range(0, 2);
      rx_max_gap = (r == 0) ? 0 : (r == 1) ? 4 : 18;
      // Long receiver hold with the sender running flat out behind it.
      if (chunk == 3) begin
        tx_max_gap   = 0;
        hold_results = 1'b1;
      end
      // Sender pause until the block has emptied.
      if (chunk == 7) wait_translations_drained();
      // Refresh a few pool pages so new tags keep turning up.
      for (int k = 0; k < 4; k++) begin
        r                 = $urandom_range(0, POOL_SIZE - 1);
        page_pool[r]      = VPN_W'({$urandom, $urandom});
        page_pool[r][5:0] = 6'($urandom_range(0, 11));
      end
      for (int n = 0; n < CHUNK_ITEMS && issued < RANDOM_ITEMS; n++) begin
        r     = $urandom_range(0, 99);
        kind  = 1'($urandom_range(0, 1));
        vpn   = ($urandom_range(0, 99) < 85) ? page_pool[$urandom_range(0, POOL_SIZE - 1)]
                                             : VPN_W'({$urandom, $urandom});
        fault = 1'($urandom_range(0, 1));
        if (last_was_lookup && r < 40) begin
          // Walker answer for the page just looked up.
          cmd   = CMD_FILL;
          vpn   = last_vpn;
          kind  = last_kind;
          fault = ($urandom_range(0, 9) == 0);
        end else if (r < 50) begin
          cmd = CMD_LOOKUP;
        end else if (r < 88) begin
          cmd   = CMD_FILL;
          fault = ($urandom_range(0, 9) == 0);
        end else if (r < 96) begin
          cmd = CMD_FLUSH;
        end else begin
          cmd = CMD_UNUSED;
        end
        send_request(cmd, kind, vpn, OFFSET_BITS'($urandom), PPN_W'($urandom), fault,
                     TARGET_BITS'($urandom_range(0, 3)));
        last_was_lookup = (cmd == CMD_LOOKUP);
        last_vpn        = vpn;
        last_kind       = kind;
        if (cmd != CMD_UNUSED) issued++;
      end
      chunk++;
    end

    // Let the last words out, then a short settling time for stray results.
    wait_translations_drained();
    repeat (10) @(posedge clk_i);
    if (translations.errors == 0 && translations.pending() == 0) begin
      $display("two_level_tlb_lookup_unit verification clean");
    end else begin
      $display("two_level_tlb_lookup_unit verification failed");
    end
    $finish;
  end

endmodule
